[rtl/ssk_pkg.sv]
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared types, constants and saturating add for the subsequence kernel.
// ----------------------------------------------------------------------------
package ssk_pkg;

   localparam int MAX_LEN_DEF   = 64;
   localparam int MAX_SUB_DEF   = 8;
   localparam int FRAC_BITS_DEF = 32;

   localparam int SYM_W     = 32;
   localparam int VAL_W     = 64;
   localparam int DECAY_W   = 17;
   localparam int SUBLEN_W  = 4;
   localparam int ACT_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [ACT_W-1:0] ACT_APPEND_A = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND_B = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COMPUTE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBLEN = 2'd1;

   localparam logic [DECAY_W-1:0]  DECAY_ONE    = 17'd65536;
   localparam logic [DECAY_W-1:0]  DECAY_RESET  = 17'd32768;
   localparam logic [SUBLEN_W-1:0] SUBLEN_RESET = 4'd2;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [SYM_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] kernel_value;
      logic             saturated;
      logic             dropped;
   } rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             sat;
   } qval_type;

   function automatic qval_type add_sat(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      qval_type       r;
      s       = {1'b0, a} + {1'b0, b};
      r.sat   = s[VAL_W];
      r.value = s[VAL_W] ? '1 : s[VAL_W-1:0];
      return r;
   endfunction

endpackage

[rtl/string_subsequence_kernel_top.sv]
// ----------------------------------------------------------------------------
// string_subsequence_kernel_top
// Gap-weighted string subsequence kernel over two loaded symbol strings.
// ----------------------------------------------------------------------------
// Append items (action 0 or 1) are taken one per cycle, also while a result
// waits on the rsp channel. A compute item runs an evaluation that starts,
// builds the power table, then for every layer below n walks each row and
// every cell (s,t), with a product for each matching symbol, then forms the
// final sum and finishes. A compute item with an empty string goes straight
// to the done state, and the result is then registered onto the rsp channel.
// The evaluation is paced by the one shared 32x32 multiplier and the single
// read port of the K' table memory. No item is accepted during an evaluation;
// csr writes are taken only while idle.
// ----------------------------------------------------------------------------
module string_subsequence_kernel_top
   import ssk_pkg::*;
#(
   parameter int MAX_LEN   = MAX_LEN_DEF,
   parameter int MAX_SUB   = MAX_SUB_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DECAY_W-1:0]   csr_wdata
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [LEN_W-1:0]    first_len_ff, second_len_ff, wr_len;
   logic                drop_ff, drop_hold_ff, busy_ff, rsp_valid_ff;
   rsp_type             rsp_data_ff;
   logic [DECAY_W-1:0]  decay_ff;
   logic [SUBLEN_W-1:0] sublen_ff;
   logic                req_fire, is_append, is_compute, wr_sel, len_full, wr_en;
   logic [IDX_W-1:0]    str_addr_a, str_addr_b;
   logic [SYM_W-1:0]    str_data_a, str_data_b;
   logic                eng_done;
   qval_type            eng_result;

   assign is_compute = (req_data.action == ACT_COMPUTE);
   assign is_append  = (req_data.action == ACT_APPEND_A) || (req_data.action == ACT_APPEND_B);
   assign wr_sel     = (req_data.action == ACT_APPEND_B);
   assign req_ready  = !busy_ff && !(rsp_valid_ff && is_compute);
   assign req_fire   = req_valid && req_ready;
   assign wr_len     = wr_sel ? second_len_ff : first_len_ff;
   assign len_full   = (wr_len == LEN_W'(MAX_LEN));
   assign wr_en      = req_fire && is_append && !len_full;
   assign csr_ready  = !busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   ssk_strings #(.MAX_LEN(MAX_LEN)) u_strings (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_sel    (wr_sel),
      .wr_addr   (wr_len[IDX_W-1:0]),
      .wr_data   (req_data.symbol),
      .rd_addr_a (str_addr_a),
      .rd_addr_b (str_addr_b),
      .rd_data_a (str_data_a),
      .rd_data_b (str_data_b)
   );

   ssk_engine #(
      .MAX_LEN   (MAX_LEN),
      .MAX_SUB   (MAX_SUB),
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (req_fire && is_compute),
      .len_a      (first_len_ff),
      .len_b      (second_len_ff),
      .sublen     (sublen_ff),
      .decay      (decay_ff),
      .str_addr_a (str_addr_a),
      .str_addr_b (str_addr_b),
      .str_data_a (str_data_a),
      .str_data_b (str_data_b),
      .done       (eng_done),
      .result     (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         drop_ff       <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         decay_ff      <= DECAY_RESET;
         sublen_ff     <= SUBLEN_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DECAY) begin
               decay_ff <= csr_wdata;
            end else if (csr_index == CSR_SUBLEN) begin
               sublen_ff <= csr_wdata[SUBLEN_W-1:0];
            end
         end
         if (req_fire && is_append) begin
            if (len_full) begin
               drop_ff <= 1'b1;
            end else if (wr_sel) begin
               second_len_ff <= second_len_ff + 1'b1;
            end else begin
               first_len_ff <= first_len_ff + 1'b1;
            end
         end
         if (req_fire && is_compute) begin
            first_len_ff  <= '0;
            second_len_ff <= '0;
            drop_ff       <= 1'b0;
            busy_ff       <= 1'b1;
         end
         if (eng_done) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && is_compute) begin
         drop_hold_ff <= drop_ff;
      end
      if (eng_done) begin
         rsp_data_ff.kernel_value <= eng_result.value;
         rsp_data_ff.saturated    <= eng_result.sat;
         rsp_data_ff.dropped      <= drop_hold_ff;
      end
   end

   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> busy_ff)
      else $error("engine finished without a pending evaluation");

   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_compute |=> busy_ff && first_len_ff == '0 && second_len_ff == '0)
      else $error("compute item did not start an evaluation");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      first_len_ff <= LEN_W'(MAX_LEN) && second_len_ff <= LEN_W'(MAX_LEN))
      else $error("string length beyond maximum");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> !rsp_valid_ff)
      else $error("result overwrites a pending item");

endmodule

[rtl/ssk_mul.sv]
// ----------------------------------------------------------------------------
// ssk_mul
// Fixed point multiplier, one 32x32 partial product per cycle, truncating
// and saturating to 64 bits.
// ----------------------------------------------------------------------------
module ssk_mul
   import ssk_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   output logic             done,
   output qval_type         result
);

   localparam int HALF_W = VAL_W / 2;

   logic [VAL_W-1:0]   a_ff, b_ff;
   logic [2*VAL_W-1:0] acc_ff, acc_in;
   logic [1:0]         step_ff;
   logic               busy_ff, done_ff;
   logic [HALF_W-1:0]  op_a, op_b;
   logic [VAL_W-1:0]   pp;
   logic [2*VAL_W-1:0] pp_sh, hi_part, shr;

   always_comb begin
      op_a = step_ff[1] ? a_ff[VAL_W-1:HALF_W] : a_ff[HALF_W-1:0];
      op_b = step_ff[0] ? b_ff[VAL_W-1:HALF_W] : b_ff[HALF_W-1:0];
      pp   = VAL_W'(op_a) * VAL_W'(op_b);
      case (step_ff)
         2'd0:    pp_sh = {{VAL_W{1'b0}}, pp};
         2'd3:    pp_sh = {pp, {VAL_W{1'b0}}};
         default: pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
      endcase
      acc_in = acc_ff + pp_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      hi_part      = acc_ff >> (VAL_W + FRAC_BITS);
      shr          = acc_ff >> FRAC_BITS;
      result.sat   = (hi_part != '0);
      result.value = result.sat ? '1 : shr[VAL_W-1:0];
   end

   assign done = done_ff;

endmodule

[rtl/ssk_strings.sv]
// ----------------------------------------------------------------------------
// ssk_strings
// Symbol memories for both strings, one write port, one read port each.
// ----------------------------------------------------------------------------
module ssk_strings
   import ssk_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic                                      wr_sel,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
   input  logic [SYM_W-1:0]                          wr_data,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr_a,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr_b,
   output logic [SYM_W-1:0]                          rd_data_a,
   output logic [SYM_W-1:0]                          rd_data_b
);

   logic [SYM_W-1:0] mem_a [MAX_LEN];
   logic [SYM_W-1:0] mem_b [MAX_LEN];

   always_ff @(posedge clock) begin
      if (wr_en && !wr_sel) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_sel) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_data_b <= mem_b[rd_addr_b];
   end

endmodule

[rtl/ssk_engine.sv]
// ----------------------------------------------------------------------------
// ssk_engine
// Evaluation sequencer: power table, layered K' table walk and final sum.
// ----------------------------------------------------------------------------
module ssk_engine
   import ssk_pkg::*;
#(
   parameter int MAX_LEN   = MAX_LEN_DEF,
   parameter int MAX_SUB   = MAX_SUB_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [$clog2(MAX_LEN+1)-1:0]              len_a,
   input  logic [$clog2(MAX_LEN+1)-1:0]              len_b,
   input  logic [SUBLEN_W-1:0]                       sublen,
   input  logic [DECAY_W-1:0]                        decay,
   output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] str_addr_a,
   output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] str_addr_b,
   input  logic [SYM_W-1:0]                          str_data_a,
   input  logic [SYM_W-1:0]                          str_data_b,
   output logic                                      done,
   output qval_type                                  result
);

   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int PW_N      = MAX_LEN + 2;
   localparam int PW_W      = $clog2(PW_N);
   localparam int SUB_W     = $clog2(MAX_SUB + 1);
   localparam int AUX_W     = 2 * LEN_W + 1;
   localparam int AUX_DEPTH = 2 ** AUX_W;
   localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_PW_GO   = 5'd1;
   localparam logic [4:0] ST_PW_WAIT = 5'd2;
   localparam logic [4:0] ST_LAYER   = 5'd3;
   localparam logic [4:0] ST_ROW     = 5'd4;
   localparam logic [4:0] ST_SYM     = 5'd5;
   localparam logic [4:0] ST_RD      = 5'd6;
   localparam logic [4:0] ST_CMP     = 5'd7;
   localparam logic [4:0] ST_MUL     = 5'd8;
   localparam logic [4:0] ST_RDT     = 5'd9;
   localparam logic [4:0] ST_TGO     = 5'd10;
   localparam logic [4:0] ST_TMUL    = 5'd11;
   localparam logic [4:0] ST_FROW    = 5'd12;
   localparam logic [4:0] ST_FSYM    = 5'd13;
   localparam logic [4:0] ST_FRD     = 5'd14;
   localparam logic [4:0] ST_FCMP    = 5'd15;
   localparam logic [4:0] ST_FGO     = 5'd16;
   localparam logic [4:0] ST_FMUL    = 5'd17;
   localparam logic [4:0] ST_DONE    = 5'd18;

   logic [4:0]       state_ff, state_in;
   logic [PW_W-1:0]  e_ff, e_in;
   logic [SUB_W-1:0] i_ff, i_in, n_ff, n_in, n_eff, n_m1;
   logic [LEN_W-1:0] s_ff, s_in, t_ff, t_in, x_ff, x_in, l1_ff, l1_in, l2_ff, l2_in;
   logic [LEN_W-1:0] s_m1, x_p1;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [VAL_W-1:0] sum_ff, sum_in, kv_ff, kv_in, lam_ff, lam_in;
   logic [VAL_W-1:0] pw_prev_ff, pw_prev_in, pw2_ff, pw2_in;
   logic             sat_ff, sat_in;
   logic [DECAY_W-1:0] decay_c;

   logic [VAL_W-1:0] pw_mem [PW_N];
   logic [VAL_W-1:0] aux_mem [AUX_DEPTH];
   logic [VAL_W-1:0] pw_rd_ff, aux_rd_ff, aux_val;
   logic [PW_W-1:0]  pw_rd_addr, pw_wr_addr;
   logic [VAL_W-1:0] pw_wr_data, aux_wr_data;
   logic             pw_we, aux_we;
   logic [AUX_W-1:0] aux_rd_addr, aux_wr_addr;
   logic             sub_one, sub_zero, sub_one_ff, sub_zero_ff;

   logic             mul_start, mul_done;
   logic [VAL_W-1:0] mul_a, mul_b;
   qval_type         mul_res;
   qval_type         add_r;

   ssk_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   always_comb begin
      if (sublen == '0) begin
         n_eff = SUB_W'(1);
      end else if (int'(sublen) > MAX_SUB) begin
         n_eff = SUB_W'(MAX_SUB);
      end else begin
         n_eff = SUB_W'(sublen);
      end
      decay_c = (decay > DECAY_ONE) ? DECAY_ONE : decay;
      lam_in  = VAL_W'(decay_c) << (FRAC_BITS - 16);
   end

   assign s_m1       = s_ff - 1'b1;
   assign x_p1       = x_ff + 1'b1;
   assign n_m1       = n_ff - 1'b1;
   assign str_addr_a = s_m1[IDX_W-1:0];
   assign str_addr_b = x_ff[IDX_W-1:0];
   assign pw_rd_addr = PW_W'(t_ff) - PW_W'(x_ff) + 1'b1;

   // table read address and the cells that are fixed by definition
   always_comb begin
      aux_rd_addr = {~i_ff[0], s_m1, x_ff};
      sub_one     = (i_ff == SUB_W'(1));
      sub_zero    = (s_ff == LEN_W'(1)) || (x_ff == '0);
      unique case (state_ff)
         ST_RDT: begin
            aux_rd_addr = {i_ff[0], s_m1, t_ff};
            sub_one     = 1'b0;
            sub_zero    = (s_ff == LEN_W'(1));
         end
         ST_FRD: begin
            aux_rd_addr = {n_m1[0], s_m1, x_ff};
            sub_one     = (n_ff == SUB_W'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pw_we) begin
         pw_mem[pw_wr_addr] <= pw_wr_data;
      end
      pw_rd_ff <= pw_mem[pw_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (aux_we) begin
         aux_mem[aux_wr_addr] <= aux_wr_data;
      end
      aux_rd_ff   <= aux_mem[aux_rd_addr];
      sub_one_ff  <= sub_one;
      sub_zero_ff <= sub_zero;
   end

   assign aux_val = sub_one_ff ? ONE_Q : (sub_zero_ff ? '0 : aux_rd_ff);

   always_comb begin
      state_in    = state_ff;
      e_in        = e_ff;
      i_in        = i_ff;
      n_in        = n_ff;
      s_in        = s_ff;
      t_in        = t_ff;
      x_in        = x_ff;
      l1_in       = l1_ff;
      l2_in       = l2_ff;
      sym_in      = sym_ff;
      sum_in      = sum_ff;
      kv_in       = kv_ff;
      pw_prev_in  = pw_prev_ff;
      pw2_in      = pw2_ff;
      sat_in      = sat_ff;
      pw_we       = 1'b0;
      pw_wr_addr  = e_ff;
      pw_wr_data  = mul_res.value;
      aux_we      = 1'b0;
      aux_wr_addr = {i_ff[0], s_ff, t_ff};
      aux_wr_data = '0;
      mul_start   = 1'b0;
      mul_a       = pw_prev_ff;
      mul_b       = lam_ff;
      add_r       = add_sat(sum_ff, mul_res.value);
      done        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               l1_in      = len_a;
               l2_in      = len_b;
               n_in       = n_eff;
               kv_in      = '0;
               sat_in     = 1'b0;
               pw_we      = 1'b1;
               pw_wr_addr = '0;
               pw_wr_data = ONE_Q;
               pw_prev_in = ONE_Q;
               e_in       = PW_W'(1);
               i_in       = SUB_W'(1);
               if (len_a == '0 || len_b == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PW_GO;
               end
            end
         end
         ST_PW_GO: begin
            mul_start = 1'b1;
            state_in  = ST_PW_WAIT;
         end
         ST_PW_WAIT: begin
            if (mul_done) begin
               pw_we      = 1'b1;
               pw_prev_in = mul_res.value;
               sat_in     = sat_ff | mul_res.sat;
               if (e_ff == PW_W'(2)) begin
                  pw2_in = mul_res.value;
               end
               if (e_ff == PW_W'(PW_N - 1)) begin
                  state_in = ST_LAYER;
               end else begin
                  e_in     = e_ff + 1'b1;
                  state_in = ST_PW_GO;
               end
            end
         end
         ST_LAYER: begin
            s_in = LEN_W'(1);
            if (i_ff == n_ff) begin
               state_in = ST_FROW;
            end else begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            state_in = ST_SYM;
         end
         ST_SYM: begin
            sym_in   = str_data_a;
            t_in     = LEN_W'(1);
            x_in     = '0;
            sum_in   = '0;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            mul_a = aux_val;
            mul_b = pw_rd_ff;
            if (str_data_b == sym_ff) begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end else if (x_p1 == t_ff) begin
               state_in = ST_RDT;
            end else begin
               x_in     = x_p1;
               state_in = ST_RD;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               sum_in = add_r.value;
               sat_in = sat_ff | mul_res.sat | add_r.sat;
               if (x_p1 == t_ff) begin
                  state_in = ST_RDT;
               end else begin
                  x_in     = x_p1;
                  state_in = ST_RD;
               end
            end
         end
         ST_RDT: begin
            state_in = ST_TGO;
         end
         ST_TGO: begin
            mul_a     = lam_ff;
            mul_b     = aux_val;
            mul_start = 1'b1;
            state_in  = ST_TMUL;
         end
         ST_TMUL: begin
            if (mul_done) begin
               aux_we      = 1'b1;
               aux_wr_data = add_r.value;
               sat_in      = sat_ff | mul_res.sat | add_r.sat;
               if (t_ff == l2_ff) begin
                  if (s_ff == l1_ff) begin
                     i_in     = i_ff + 1'b1;
                     state_in = ST_LAYER;
                  end else begin
                     s_in     = s_ff + 1'b1;
                     state_in = ST_ROW;
                  end
               end else begin
                  t_in     = t_ff + 1'b1;
                  x_in     = '0;
                  sum_in   = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_FROW: begin
            state_in = ST_FSYM;
         end
         ST_FSYM: begin
            sym_in   = str_data_a;
            x_in     = '0;
            sum_in   = '0;
            state_in = ST_FRD;
         end
         ST_FRD: begin
            state_in = ST_FCMP;
         end
         ST_FCMP: begin
            add_r = add_sat(sum_ff, aux_val);
            if (str_data_b == sym_ff) begin
               sum_in = add_r.value;
               sat_in = sat_ff | add_r.sat;
            end
            if (x_p1 == l2_ff) begin
               state_in = ST_FGO;
            end else begin
               x_in     = x_p1;
               state_in = ST_FRD;
            end
         end
         ST_FGO: begin
            mul_a     = sum_ff;
            mul_b     = pw2_ff;
            mul_start = 1'b1;
            state_in  = ST_FMUL;
         end
         ST_FMUL: begin
            add_r = add_sat(kv_ff, mul_res.value);
            if (mul_done) begin
               kv_in  = add_r.value;
               sat_in = sat_ff | mul_res.sat | add_r.sat;
               if (s_ff == l1_ff) begin
                  state_in = ST_DONE;
               end else begin
                  s_in     = s_ff + 1'b1;
                  state_in = ST_FROW;
               end
            end
         end
         ST_DONE: begin
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff       <= e_in;
      i_ff       <= i_in;
      n_ff       <= n_in;
      s_ff       <= s_in;
      t_ff       <= t_in;
      x_ff       <= x_in;
      l1_ff      <= l1_in;
      l2_ff      <= l2_in;
      sym_ff     <= sym_in;
      sum_ff     <= sum_in;
      kv_ff      <= kv_in;
      pw_prev_ff <= pw_prev_in;
      pw2_ff     <= pw2_in;
      sat_ff     <= sat_in;
      if (state_ff == ST_IDLE && start) begin
         lam_ff <= lam_in;
      end
   end

   assign result.value = kv_ff;
   assign result.sat   = sat_ff;

endmodule

[bench/ssk_checker.sv]
// ----------------------------------------------------------------------------
// ssk_checker
// Watches the req, rsp and csr channels of the subsequence kernel, keeps its
// own copy of the two strings and the registers, predicts the kernel value
// and flags of each compute item and compares them with the rsp items.
// ----------------------------------------------------------------------------
module ssk_checker
   import ssk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DECAY_W-1:0]   csr_wdata,
   output int                   fail_count,
   output int                   pending
);

   localparam int LEN = MAX_LEN_DEF;
   localparam int FB  = FRAC_BITS_DEF;

   logic [DECAY_W-1:0]  decay_reg;
   logic [SUBLEN_W-1:0] sublen_reg;
   logic [SYM_W-1:0]    str_a [LEN];
   logic [SYM_W-1:0]    str_b [LEN];
   int                  len_a, len_b;
   bit                  drop_seen;
   rsp_type             kernel_queue [$];

   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, ref bit sat);
      logic [127:0] p;
      p = a * b;
      p = p >> FB;
      if (p[127:64] != 0) begin
         sat = 1;
         return '1;
      end
      return p[63:0];
   endfunction

   function automatic logic [63:0] qadd(logic [63:0] a, logic [63:0] b, ref bit sat);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[64]) begin
         sat = 1;
         return '1;
      end
      return s[63:0];
   endfunction

   function automatic rsp_type kernel_of_strings();
      logic [63:0] pw [LEN+2];
      logic [63:0] kp [2][LEN+1][LEN+1];
      logic [63:0] lam, kv, sum;
      logic [16:0] d;
      int          n, cur, prv, fin;
      bit          sat;
      rsp_type     r;
      sat = 0;
      kv  = 0;
      n = sublen_reg;
      if (n < 1) n = 1;
      if (n > MAX_SUB_DEF) n = MAX_SUB_DEF;
      d = (decay_reg > DECAY_ONE) ? DECAY_ONE : decay_reg;
      lam = 64'(d) << (FB - 16);
      pw[0] = 64'd1 << FB;
      for (int e = 1; e < LEN + 2; e++) pw[e] = qmul(pw[e-1], lam, sat);
      for (int s = 0; s <= len_a; s++)
         for (int t = 0; t <= len_b; t++) kp[0][s][t] = 64'd1 << FB;
      for (int i = 1; i < n; i++) begin
         cur = i & 1;
         prv = cur ^ 1;
         for (int t = 0; t <= len_b; t++) kp[cur][0][t] = 0;
         for (int s = 1; s <= len_a; s++) begin
            kp[cur][s][0] = 0;
            for (int t = 1; t <= len_b; t++) begin
               sum = 0;
               for (int x = 0; x < t; x++)
                  if (str_b[x] == str_a[s-1])
                     sum = qadd(sum, qmul(kp[prv][s-1][x], pw[t-x+1], sat), sat);
               kp[cur][s][t] = qadd(qmul(lam, kp[cur][s-1][t], sat), sum, sat);
            end
         end
      end
      fin = (n - 1) & 1;
      for (int s = 1; s <= len_a; s++) begin
         sum = 0;
         for (int x = 0; x < len_b; x++)
            if (str_b[x] == str_a[s-1]) sum = qadd(sum, kp[fin][s-1][x], sat);
         kv = qadd(kv, qmul(sum, pw[2], sat), sat);
      end
      r.kernel_value = kv;
      r.saturated    = sat;
      r.dropped      = drop_seen;
      return r;
   endfunction

   assign pending = kernel_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         decay_reg  <= DECAY_RESET;
         sublen_reg <= SUBLEN_RESET;
         len_a = 0;
         len_b = 0;
         drop_seen = 0;
         fail_count <= 0;
         kernel_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DECAY) decay_reg <= csr_wdata;
            else if (csr_index == CSR_SUBLEN) sublen_reg <= csr_wdata[SUBLEN_W-1:0];
         end
         if (req_valid && req_ready) begin
            case (req_data.action)
               ACT_APPEND_A: begin
                  if (len_a < LEN) str_a[len_a++] = req_data.symbol;
                  else drop_seen = 1;
               end
               ACT_APPEND_B: begin
                  if (len_b < LEN) str_b[len_b++] = req_data.symbol;
                  else drop_seen = 1;
               end
               ACT_COMPUTE: begin
                  kernel_queue.push_back(kernel_of_strings());
                  len_a = 0;
                  len_b = 0;
                  drop_seen = 0;
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (kernel_queue.size() == 0) begin
               $error("unexpected rsp item %h", rsp_data);
               errs++;
            end else begin
               want = kernel_queue.pop_front();
               if (want.kernel_value !== rsp_data.kernel_value) begin
                  $error("kernel_value: expected %h actual %h",
                         want.kernel_value, rsp_data.kernel_value);
                  errs++;
               end
               if (want.saturated !== rsp_data.saturated) begin
                  $error("saturated: expected %b actual %b",
                         want.saturated, rsp_data.saturated);
                  errs++;
               end
               if (want.dropped !== rsp_data.dropped) begin
                  $error("dropped: expected %b actual %b",
                         want.dropped, rsp_data.dropped);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

[bench/string_subsequence_kernel_top_tb.sv]
// ----------------------------------------------------------------------------
// string_subsequence_kernel_top_tb
// Drives loads and compute items into the kernel under several decay and
// length settings with random idling on both sides; a checker predicts and
// compares every rsp item.
// ----------------------------------------------------------------------------
module string_subsequence_kernel_top_tb;
   import ssk_pkg::*;

   localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DECAY_W-1:0]   csr_wdata;
   int                   fail_count;
   int                   pending;
   int                   send_idle_pct;
   int                   recv_idle_pct;
   logic                 hold_go;
   int                   hold_left;
   bit                   hold_used;
   logic [SYM_W-1:0]     alphabet [4];

   string_subsequence_kernel_top dut (.*);

   ssk_checker checker_i (.*);

   always begin
      clock = 1;
      #5;
      clock = 0;
      #5;
   end

   // receiver: random stall, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         hold_left <= 0;
         hold_used <= 0;
      end else if (hold_go && !hold_used) begin
         hold_used <= 1;
         hold_left <= 3000;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 0;
         hold_left <= hold_left - 1;
      end else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // returns at the falling edge after the accepting edge, valid still high
   task automatic send_item(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data  <= '{action: act, symbol: sym};
      #1;
      while (!req_ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DECAY_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      #1;
      while (!csr_ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   function automatic logic [SYM_W-1:0] pick_symbol();
      if ($urandom_range(9) == 0) return $urandom;
      return alphabet[$urandom_range(3)];
   endfunction

   // one pair of strings and a compute; lengths mostly small
   task automatic random_pair(int max_a, int max_b);
      int la, lb;
      la = $urandom_range(max_a);
      lb = $urandom_range(max_b);
      while (la > 0 || lb > 0) begin
         if (la > 0 && (lb == 0 || $urandom_range(1))) begin
            send_item(ACT_APPEND_A, pick_symbol());
            la--;
         end else begin
            send_item(ACT_APPEND_B, pick_symbol());
            lb--;
         end
      end
      if ($urandom_range(19) == 0) send_item(ACT_RESERVED, $urandom);
      send_item(ACT_COMPUTE, $urandom);
   endtask

   task automatic random_phase(int pairs);
      for (int k = 0; k < pairs; k++) begin
         if ($urandom_range(29) == 0) random_pair(24, 24);
         else random_pair(8, 8);
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = CSR_DECAY;
      csr_wdata = '0;
      hold_go = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int k = 0; k < 4; k++) alphabet[k] = $urandom;
      repeat (5) @(negedge clock);
      reset = 0;

      // directed: empty strings, extreme symbols, unused action, overflow
      send_item(ACT_COMPUTE, 0);
      send_item(ACT_APPEND_A, 32'h0);
      send_item(ACT_APPEND_A, 32'hFFFF_FFFF);
      send_item(ACT_APPEND_B, 32'hFFFF_FFFF);
      send_item(ACT_APPEND_B, 32'h0);
      send_item(ACT_RESERVED, 32'h5555_5555);
      send_item(ACT_APPEND_B, 32'hAAAA_AAAA);
      send_item(ACT_COMPUTE, 0);
      send_item(ACT_APPEND_A, 32'h1);
      send_item(ACT_COMPUTE, 0);
      drain();
      write_csr(CSR_DECAY, DECAY_ONE);
      write_csr(CSR_SUBLEN, DECAY_W'(1));
      for (int k = 0; k < 66; k++) send_item(ACT_APPEND_A, alphabet[k % 2]);
      for (int k = 0; k < 65; k++) send_item(ACT_APPEND_B, alphabet[k % 2]);
      send_item(ACT_COMPUTE, 0);
      drain();
      write_csr(CSR_DECAY, 17'h1FFFF);
      write_csr(CSR_SUBLEN, DECAY_W'(8));
      for (int k = 0; k < 20; k++) send_item(ACT_APPEND_A, alphabet[0]);
      for (int k = 0; k < 20; k++) send_item(ACT_APPEND_B, alphabet[0]);
      send_item(ACT_COMPUTE, 0);
      drain();

      // random phases across settings and idling profiles
      send_idle_pct = 28;
      recv_idle_pct = 86;
      write_csr(CSR_DECAY, 17'd0);
      write_csr(CSR_SUBLEN, DECAY_W'(0));
      random_phase(30);
      drain();
      write_csr(CSR_DECAY, 17'd49152);
      write_csr(CSR_SUBLEN, DECAY_W'(3));
      random_phase(30);
      drain();
      send_idle_pct = 86;
      recv_idle_pct = 28;
      write_csr(CSR_DECAY, DECAY_W'($urandom_range(65536)));
      write_csr(CSR_SUBLEN, DECAY_W'(15));
      random_phase(20);
      drain();
      write_csr(CSR_DECAY, DECAY_ONE);
      write_csr(CSR_SUBLEN, DECAY_W'(2));
      random_phase(25);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_DECAY, 17'd1);
      write_csr(CSR_SUBLEN, DECAY_W'(4));
      hold_go = 1;
      random_phase(22);
      drain();
      write_csr(CSR_DECAY, DECAY_W'($urandom_range(65536)));
      write_csr(CSR_SUBLEN, DECAY_W'($urandom_range(1, 8)));
      random_phase(22);
      drain();

      if (fail_count == 0) $display("PASS string_subsequence_kernel_top");
      else $display("FAIL string_subsequence_kernel_top");
      $finish;
   end

   initial begin
      #200000000;
      $display("FAIL string_subsequence_kernel_top");
      $finish;
   end

endmodule

[files.f]
rtl/ssk_pkg.sv
rtl/ssk_mul.sv
rtl/ssk_strings.sv
rtl/ssk_engine.sv
rtl/string_subsequence_kernel_top.sv
bench/ssk_checker.sv
bench/string_subsequence_kernel_top_tb.sv
